// ===== sv/nvi_pkg.sv =====
package nvi_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned WeightW = 17;
  localparam int unsigned OutW    = 16;
  localparam int unsigned StatW   = 2;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned NormW   = 31;   // normalized magnitude, MSB at bit 30
  localparam int unsigned SumW    = 64;
  localparam int unsigned UnitW   = 32;   // Q2.30 magnitude incl. 2^30
  localparam int unsigned BlendW  = 49;   // |P| <= 2^46 * 2 with margin
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QuoW    = 31;   // quotient width for F = 30
  localparam int unsigned DivSteps = 47;  // not used; the F = 30 dividend is DW = 62 bits

  typedef enum logic [StatW-1:0] {
    StOk        = 2'd0,
    StZeroEnd   = 2'd1,
    StZeroBlend = 2'd2,
    StRsvd      = 2'd3
  } status_e;

  typedef enum logic [IdxW-1:0] {
    RegFirstX  = 3'd0,
    RegFirstY  = 3'd1,
    RegFirstZ  = 3'd2,
    RegSecondX = 3'd3,
    RegSecondY = 3'd4,
    RegSecondZ = 3'd5
  } reg_idx_e;

  // Per-vector working set; nvi_norm keeps its own per-stage arrays instead.
  typedef struct packed {
    logic [2:0]          neg;
    logic [SumW-1:0]     m0;
    logic [SumW-1:0]     m1;
    logic [SumW-1:0]     m2;
    logic [SumW-1:0]     rem;   // sqrt remainder
    logic [SumW-1:0]     root;  // sqrt partial root
    logic                zero;
  } vec_t;

endpackage

// ===== sv/nvi_norm.sv =====
// Fully pipelined vector normalizer. One transaction enters per enabled cycle; the
// square root runs as a chain of one-bit cells, the three divisions as chains of
// restoring-divide cells. The normalizing shift is a priority encode plus shift.
module nvi_norm
  import nvi_pkg::*;
#(
  parameter int unsigned InW  = 49,
  parameter int unsigned Frac = 30,
  parameter int unsigned TagW = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [InW-1:0]  v0_i,
  input  logic signed [InW-1:0]  v1_i,
  input  logic signed [InW-1:0]  v2_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   vld_o,
  output logic signed [Frac+1:0] r0_o,
  output logic signed [Frac+1:0] r1_o,
  output logic signed [Frac+1:0] r2_o,
  output logic                   zero_o,
  output logic [TagW-1:0]        tag_o
);

  // dividend is m * 2^Frac plus half the root, one bit above m * 2^Frac
  localparam int unsigned DW  = NormW + Frac + 1;   // dividend width
  localparam int unsigned QW  = Frac + 1;           // quotient bits needed (L >= m)
  localparam int unsigned SqS = SqrtSteps;          // sqrt cells (result below 2^32)
  localparam int unsigned NS  = 1 + SqS + QW + 1;   // index of the last stage (stages 0..NS)
  localparam int unsigned SW  = $clog2(InW + 1);

  // ---- stage 0: magnitude, align to [2^30, 2^31)
  logic [InW-1:0] a0, a1, a2, big;
  logic [SW-1:0]  msb;
  logic [NormW-1:0] n0, n1, n2;
  always_comb begin
    a0 = v0_i[InW-1] ? InW'(-v0_i) : InW'(v0_i);
    a1 = v1_i[InW-1] ? InW'(-v1_i) : InW'(v1_i);
    a2 = v2_i[InW-1] ? InW'(-v2_i) : InW'(v2_i);
    big = a0 | a1 | a2;  // same leading bit as the max
    msb = '0;
    for (int i = 0; i < InW; i++) begin
      if (big[i]) msb = SW'(i);
    end
    if (msb >= SW'(30)) begin
      n0 = NormW'(a0 >> (msb - SW'(30)));
      n1 = NormW'(a1 >> (msb - SW'(30)));
      n2 = NormW'(a2 >> (msb - SW'(30)));
    end else begin
      n0 = NormW'(a0) << (SW'(30) - msb);
      n1 = NormW'(a1) << (SW'(30) - msb);
      n2 = NormW'(a2) << (SW'(30) - msb);
    end
  end

  // pipeline payload per stage
  logic [NS:0]              vld_q;
  logic [TagW-1:0]          tag_q   [NS+1];
  logic [2:0]               neg_q   [NS+1];
  logic                     zer_q   [NS+1];
  logic [NormW-1:0]         m_q     [NS+1][3];
  logic [SumW-1:0]          s_q     [NS+1];   // sqrt: remaining value
  logic [SumW-1:0]          rt_q    [NS+1];   // sqrt: root
  logic [DW-1:0]            rm_q    [NS+1][3];// div: partial remainder / dividend
  logic [QW-1:0]            qt_q    [NS+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], vld_i};
    end
  end

  assign vld_o = vld_q[NS];

  // stage 0 register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0]   <= tag_i;
      neg_q[0]   <= {v2_i[InW-1], v1_i[InW-1], v0_i[InW-1]};
      zer_q[0]   <= (big == '0);
      m_q[0][0]  <= n0;
      m_q[0][1]  <= n1;
      m_q[0][2]  <= n2;
      rm_q[0][0] <= '0;
      rm_q[0][1] <= '0;
      rm_q[0][2] <= '0;
      qt_q[0][0] <= '0;
      qt_q[0][1] <= '0;
      qt_q[0][2] <= '0;
      s_q[0]     <= '0;
      rt_q[0]    <= '0;
    end
  end

  // stage 1: sum of squares (three 31x31 products, summed)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[1]  <= tag_q[0];
      neg_q[1]  <= neg_q[0];
      zer_q[1]  <= zer_q[0];
      m_q[1]    <= m_q[0];
      rm_q[1]   <= rm_q[0];
      qt_q[1]   <= qt_q[0];
      s_q[1]    <= SumW'(m_q[0][0]) * SumW'(m_q[0][0]) +
                   SumW'(m_q[0][1]) * SumW'(m_q[0][1]) +
                   SumW'(m_q[0][2]) * SumW'(m_q[0][2]);
      rt_q[1]   <= '0;
    end
  end

  // sqrt cells: one result bit each, bit b = 2^(2*(SqS-1-k))
  for (genvar k = 0; k < SqS; k++) begin : g_sq
    localparam int unsigned St = 1 + k;
    logic [SumW-1:0] b, t;
    logic            ge;
    always_comb begin
      b  = SumW'(1) << (2 * (SqS - 1 - k));
      t  = rt_q[St] + b;
      ge = s_q[St] >= t;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[St+1] <= tag_q[St];
        neg_q[St+1] <= neg_q[St];
        zer_q[St+1] <= zer_q[St];
        m_q[St+1]   <= m_q[St];
        qt_q[St+1]  <= qt_q[St];
        s_q[St+1]   <= ge ? s_q[St] - t : s_q[St];
        rt_q[St+1]  <= ge ? (rt_q[St] >> 1) + b : rt_q[St] >> 1;
        for (int c = 0; c < 3; c++) begin
          // on the last sqrt cell, load the rounded dividend
          if (k == SqS - 1) begin
            rm_q[St+1][c] <= (DW'(m_q[St][c]) << Frac) +
                             DW'((ge ? (rt_q[St] >> 1) + b : rt_q[St] >> 1) >> 1);
          end else begin
            rm_q[St+1][c] <= rm_q[St][c];
          end
        end
      end
    end
  end

  // divide cells: one quotient bit each, MSB first; divisor L < 2^32
  for (genvar k = 0; k < QW; k++) begin : g_dv
    localparam int unsigned St = 1 + SqS + k;
    localparam int unsigned Sh = QW - 1 - k;
    logic [DW+Sh-1:0] dsh;
    logic [2:0]       ge;
    always_comb begin
      dsh = (DW+Sh)'(rt_q[St]) << Sh;
      for (int c = 0; c < 3; c++) ge[c] = (DW+Sh)'(rm_q[St][c]) >= dsh;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[St+1] <= tag_q[St];
        neg_q[St+1] <= neg_q[St];
        zer_q[St+1] <= zer_q[St];
        m_q[St+1]   <= m_q[St];
        s_q[St+1]   <= s_q[St];
        rt_q[St+1]  <= rt_q[St];
        for (int c = 0; c < 3; c++) begin
          rm_q[St+1][c] <= ge[c] ? DW'((DW+Sh)'(rm_q[St][c]) - dsh) : rm_q[St][c];
          qt_q[St+1][c] <= {qt_q[St][c][QW-2:0], ge[c]};
        end
      end
    end
  end

  // final cell: clamp, sign, zero
  localparam int unsigned Fs = NS - 1;
  logic signed [Frac+1:0] r_d [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [Frac+1:0] q;
      q = (qt_q[Fs][c] > QW'(64'd1 << Frac)) ? (Frac+2)'(64'd1 << Frac)
                                              : (Frac+2)'(qt_q[Fs][c]);
      if (zer_q[Fs])          r_d[c] = '0;
      else if (neg_q[Fs][c])  r_d[c] = -$signed(q);
      else                    r_d[c] = $signed(q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[NS] <= tag_q[Fs];
      zer_q[NS] <= zer_q[Fs];
      neg_q[NS] <= neg_q[Fs];
      m_q[NS]   <= m_q[Fs];
      s_q[NS]   <= s_q[Fs];
      rt_q[NS]  <= rt_q[Fs];
      rm_q[NS]  <= rm_q[Fs];
      qt_q[NS]  <= qt_q[Fs];
      r0_o      <= r_d[0];
      r1_o      <= r_d[1];
      r2_o      <= r_d[2];
    end
  end
  assign zero_o = zer_q[NS];
  assign tag_o  = tag_q[NS];

endmodule

// ===== sv/nvi_blend.sv =====
// Blend cell: P_i = (65536 - a) * e1_i + a * e2_i, two products per lane,
// registered before the add.
module nvi_blend
  import nvi_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [WeightW-1:0]      w_i,
  input  logic signed [UnitW-1:0] e1_i [3],
  input  logic signed [UnitW-1:0] e2_i [3],
  output logic signed [BlendW-1:0] p_o [3]
);

  logic signed [BlendW-1:0] pa_q [3];
  logic signed [BlendW-1:0] pb_q [3];
  logic signed [WeightW:0]  wa, wb;

  assign wb = $signed({1'b0, w_i});
  assign wa = $signed((WeightW+1)'(65536) - {1'b0, w_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        pa_q[c] <= BlendW'(wa) * BlendW'(e1_i[c]);
        pb_q[c] <= BlendW'(wb) * BlendW'(e2_i[c]);
        p_o[c]  <= pa_q[c] + pb_q[c];
      end
    end
  end

endmodule

// ===== sv/normalized_vector_interpolation.sv =====
// Normalized linear interpolation of two 3D endpoint vectors (signed Q4.12
// registers) by a weight a (Q1.16, saturated at 1.0), returning a Q1.14 unit
// vector with status. The block is a pipeline of one-bit cells (square root
// and restoring division) and takes one transaction per cycle while the output
// is not stalled. The path runs through the two endpoint normalizers in
// parallel, then the two blend stages, the third normalizer and the output
// register. An output register with a stall-on-not-ready enable holds
// the result; the whole pipeline freezes while the output waits. Endpoints are
// normalized per transaction, so register writes take effect for the next
// transaction.
module normalized_vector_interpolation
  import nvi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [CompW-1:0]    cfg_data_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [WeightW-1:0]  weight_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [OutW-1:0] out_x_o,
  output logic signed [OutW-1:0] out_y_o,
  output logic signed [OutW-1:0] out_z_o,
  output logic [StatW-1:0]    status_o
);

  logic signed [CompW-1:0] f_q [3];
  logic signed [CompW-1:0] s_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q[0] <= CompW'(4096); f_q[1] <= '0; f_q[2] <= '0;
      s_q[0] <= '0; s_q[1] <= CompW'(4096); s_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFirstX:  f_q[0] <= cfg_data_i;
        RegFirstY:  f_q[1] <= cfg_data_i;
        RegFirstZ:  f_q[2] <= cfg_data_i;
        RegSecondX: s_q[0] <= cfg_data_i;
        RegSecondY: s_q[1] <= cfg_data_i;
        RegSecondZ: s_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  logic [WeightW-1:0] wsat;
  assign wsat = (weight_i > WeightW'(65536)) ? WeightW'(65536) : weight_i;

  // endpoint normalizers, weight rides as tag
  logic                     v1, v2, z1, z2;
  logic signed [UnitW-1:0]  e1 [3], e2 [3];
  logic [WeightW-1:0]       t1, t2;

  nvi_norm #(.InW(CompW), .Frac(30), .TagW(WeightW)) u_n1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(valid_i && en),
    .v0_i(f_q[0]), .v1_i(f_q[1]), .v2_i(f_q[2]), .tag_i(wsat),
    .vld_o(v1), .r0_o(e1[0]), .r1_o(e1[1]), .r2_o(e1[2]), .zero_o(z1), .tag_o(t1)
  );
  nvi_norm #(.InW(CompW), .Frac(30), .TagW(WeightW)) u_n2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(valid_i && en),
    .v0_i(s_q[0]), .v1_i(s_q[1]), .v2_i(s_q[2]), .tag_i(wsat),
    .vld_o(v2), .r0_o(e2[0]), .r1_o(e2[1]), .r2_o(e2[2]), .zero_o(z2), .tag_o(t2)
  );

  logic signed [BlendW-1:0] p [3];
  nvi_blend u_bl (.clk_i, .en_i(en), .w_i(t1), .e1_i(e1), .e2_i(e2), .p_o(p));

  // carry valid and endpoint-zero flag alongside the two blend stages
  logic [1:0] bv_q, bz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
      bz_q <= '0;
    end else if (en) begin
      bv_q <= {bv_q[0], v1 && v2};
      bz_q <= {bz_q[0], z1 || z2};
    end
  end

  logic                  v3, z3, ez;
  logic signed [15:0]    r [3];
  nvi_norm #(.InW(BlendW), .Frac(14), .TagW(1)) u_n3 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(bv_q[1]),
    .v0_i(p[0]), .v1_i(p[1]), .v2_i(p[2]), .tag_i(bz_q[1]),
    .vld_o(v3), .r0_o(r[0]), .r1_o(r[1]), .r2_o(r[2]), .zero_o(z3), .tag_o(ez)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ez) begin
        out_x_o <= '0; out_y_o <= '0; out_z_o <= '0; status_o <= StZeroEnd;
      end else if (z3) begin
        out_x_o <= '0; out_y_o <= '0; out_z_o <= '0; status_o <= StZeroBlend;
      end else begin
        out_x_o <= r[0]; out_y_o <= r[1]; out_z_o <= r[2]; status_o <= StOk;
      end
    end
  end

endmodule

// ===== sv/nvi_checker.sv =====
module nvi_checker
  import nvi_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  valid_o,
  input logic                  ready_i,
  input logic                  ready_o,
  input logic signed [OutW-1:0] out_x_o,
  input logic signed [OutW-1:0] out_y_o,
  input logic signed [OutW-1:0] out_z_o,
  input logic [StatW-1:0]      status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(out_x_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o != StRsvd)
    else $error("reserved status");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != StOk |-> out_x_o == 0 && out_y_o == 0 && out_z_o == 0)
    else $error("error result not zero");

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |-> !ready_o)
    else $error("input taken while output stalled");

endmodule

bind normalized_vector_interpolation nvi_checker u_chk (.*);
